// ===== rtl/core/mbfc_pkg.sv =====
`default_nettype none

package mbfc_pkg;

    // operation codes
    localparam logic [2:0] FUNC_MBF32_TO_IEEE32 = 3'd0;
    localparam logic [2:0] FUNC_MBF64_TO_IEEE64 = 3'd1;
    localparam logic [2:0] FUNC_IEEE32_TO_MBF32 = 3'd2;
    localparam logic [2:0] FUNC_IEEE64_TO_MBF64 = 3'd3;
    localparam logic [2:0] FUNC_MBF64_TO_MBF32  = 3'd4;

    localparam int MBF_EXP_W  = 8;
    localparam int MBF_MAN_W  = 55;
    localparam int MBF32_MAN_W = 23;
    localparam int IEEE_W     = 64;
    localparam int DBL_EXP_W  = 11;
    localparam int DBL_MAN_W  = 52;

    // mbf exponent e maps to ieee double exponent e + 894
    localparam logic [DBL_EXP_W-1:0] DBL_EXP_OFFSET = 11'd894;
    localparam logic [DBL_EXP_W-1:0] DBL_EXP_SAT    = 11'd1150;
    localparam logic [DBL_EXP_W-1:0] DBL_EXP_SPECIAL = 11'd2047;
    localparam logic [MBF_EXP_W-1:0] SGL_EXP_SPECIAL = 8'd255;
    localparam logic [MBF_EXP_W-1:0] SGL_EXP_SAT     = 8'd254;
    localparam logic [MBF_EXP_W-1:0] MBF_EXP_MAX     = 8'd255;
    localparam logic [31:0]          HALF_LSB32      = 32'h8000_0000;

    localparam logic [MBF_MAN_W-1:0] MAN_ALL_ONES55 = {MBF_MAN_W{1'b1}};
    localparam logic [MBF_MAN_W-1:0] MAN_ALL_ONES23 =
        {{(MBF_MAN_W-MBF32_MAN_W){1'b0}}, {MBF32_MAN_W{1'b1}}};

    typedef struct packed {
        logic [2:0]           func;
        logic                 in_sign;
        logic [MBF_EXP_W-1:0] in_exponent;
        logic [MBF_MAN_W-1:0] in_mantissa;
        logic [IEEE_W-1:0]    in_ieee_word;
    } t_in_item;

    typedef struct packed {
        logic [IEEE_W-1:0]    out_ieee_word;
        logic                 out_sign;
        logic [MBF_EXP_W-1:0] out_exponent;
        logic [MBF_MAN_W-1:0] out_mantissa;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/mbf_ieee_format_converter.sv =====
// an accepted start passes the operand register r_in and then the result register r_result before the o_done strobe
// throughput: one item per cycle, o_busy is always low
// the result is shown for exactly one cycle; the receiver cannot stall it
// reset: synchronous active-low i_rst_n clears the valid flags only,
// no item in flight survives a reset
`default_nettype none

module mbf_ieee_format_converter
    import mbfc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_in_item  i_item,
    output logic           o_busy,
    output logic           o_done,
    output t_out_item      o_result
);

    // stage 1: operand register
    t_in_item  r_in;
    logic      r_in_vld;
    // stage 2: result register
    t_out_item r_result;
    logic      r_done;
    t_out_item n_result;

    logic accept;

    // fields of the registered operand
    logic                 sign;
    logic [MBF_EXP_W-1:0] mexp;
    logic [MBF_MAN_W-1:0] mman;
    logic [IEEE_W-1:0]    word;

    // mbf64 -> ieee64 rounding path
    logic [DBL_EXP_W-1:0]           d_exp;
    logic                           d_round;
    logic [DBL_EXP_W+DBL_MAN_W-1:0] d_body;

    // ieee single fields
    logic                 s_sign;
    logic [MBF_EXP_W-1:0] s_exp;

    // ieee double fields
    logic                 q_sign;
    logic [DBL_EXP_W-1:0] q_exp;
    logic [DBL_EXP_W-1:0] q_exp_mbf;

    // mbf64 -> mbf32 rounding path
    logic [31:0]                    n_low;
    logic                           n_up;
    logic [MBF_EXP_W+MBF32_MAN_W:0] n_sum;

    // the unit never stalls
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    assign sign = r_in.in_sign;
    assign mexp = r_in.in_exponent;
    assign mman = r_in.in_mantissa;
    assign word = r_in.in_ieee_word;

    // rebias by 894, drop 3 mantissa bits, round to nearest even;
    // a carry out of the mantissa walks straight into the exponent field
    assign d_exp   = {{(DBL_EXP_W-MBF_EXP_W){1'b0}}, mexp} + DBL_EXP_OFFSET;
    assign d_round = mman[2] && ((mman[1:0] != 2'b00) || mman[3]);
    assign d_body  = {d_exp, mman[MBF_MAN_W-1:3]}
                   + {{(DBL_EXP_W+DBL_MAN_W-1){1'b0}}, d_round};

    assign s_sign = word[31];
    assign s_exp  = word[30:23];

    assign q_sign    = word[63];
    assign q_exp     = word[62:52];
    assign q_exp_mbf = q_exp - DBL_EXP_OFFSET;

    // keep the top 23 bits, round on the low 32, ties to even;
    // the 9-bit exponent plus mantissa sum flags overflow in its top bit
    assign n_low = mman[31:0];
    assign n_up  = (n_low > HALF_LSB32) || ((n_low == HALF_LSB32) && mman[32]);
    assign n_sum = {1'b0, mexp, mman[MBF_MAN_W-1:32]}
                 + {{(MBF_EXP_W+MBF32_MAN_W){1'b0}}, n_up};

    always_comb begin
        n_result = '0;
        case (r_in.func)
            FUNC_MBF32_TO_IEEE32: begin
                if (mexp == '0) begin
                    n_result.out_ieee_word = '0;
                end else if (mexp <= 8'd2) begin
                    // too small for a normal single: signed zero
                    n_result.out_ieee_word = {32'd0, sign, 31'd0};
                end else begin
                    n_result.out_ieee_word = {32'd0, sign, mexp - 8'd2,
                                              mman[MBF32_MAN_W-1:0]};
                end
            end
            FUNC_MBF64_TO_IEEE64: begin
                if (mexp != '0) begin
                    n_result.out_ieee_word = {sign, d_body};
                end
            end
            FUNC_IEEE32_TO_MBF32: begin
                if (s_exp == SGL_EXP_SPECIAL || s_exp >= SGL_EXP_SAT) begin
                    // inf, nan and exponent overflow saturate
                    n_result.out_sign     = s_sign;
                    n_result.out_exponent = MBF_EXP_MAX;
                    n_result.out_mantissa = MAN_ALL_ONES23;
                end else if (s_exp != '0) begin
                    n_result.out_sign     = s_sign;
                    n_result.out_exponent = s_exp + 8'd2;
                    n_result.out_mantissa =
                        {{(MBF_MAN_W-MBF32_MAN_W){1'b0}}, word[MBF32_MAN_W-1:0]};
                end
            end
            FUNC_IEEE64_TO_MBF64: begin
                if (q_exp == DBL_EXP_SPECIAL || q_exp >= DBL_EXP_SAT) begin
                    n_result.out_sign     = q_sign;
                    n_result.out_exponent = MBF_EXP_MAX;
                    n_result.out_mantissa = MAN_ALL_ONES55;
                end else if (q_exp > DBL_EXP_OFFSET) begin
                    n_result.out_sign     = q_sign;
                    n_result.out_exponent = q_exp_mbf[MBF_EXP_W-1:0];
                    n_result.out_mantissa = {word[DBL_MAN_W-1:0], 3'b000};
                end
            end
            FUNC_MBF64_TO_MBF32: begin
                if (mexp != '0) begin
                    n_result.out_sign = sign;
                    if (n_sum[MBF_EXP_W+MBF32_MAN_W]) begin
                        n_result.out_exponent = MBF_EXP_MAX;
                        n_result.out_mantissa = MAN_ALL_ONES23;
                    end else begin
                        n_result.out_exponent =
                            n_sum[MBF_EXP_W+MBF32_MAN_W-1:MBF32_MAN_W];
                        n_result.out_mantissa =
                            {{(MBF_MAN_W-MBF32_MAN_W){1'b0}},
                             n_sum[MBF32_MAN_W-1:0]};
                    end
                end
            end
            default: begin
                // unused codes give an all-zero item
                n_result = '0;
            end
        endcase
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_in_vld <= accept;
            r_done   <= r_in_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // every accepted item comes out through r_in_vld and then r_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done)
        else $error("accepted item did not complete after two cycles");

    // ieee and mbf result fields never carry data at once
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.out_ieee_word != '0) |->
        (!o_result.out_sign && o_result.out_exponent == '0 &&
         o_result.out_mantissa == '0))
        else $error("ieee and mbf result fields both set");

    // an mbf zero is all zero
    a_mbf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.out_exponent == '0) |->
        (!o_result.out_sign && o_result.out_mantissa == '0))
        else $error("mbf zero with nonzero sign or mantissa");

endmodule

`default_nettype wire

// ===== test/mbf_ieee_format_converter_tb.sv =====
`default_nettype none

module mbf_ieee_format_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbfc_pkg::*;

    // func codes past the last conversion, the block must zero every field
    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int MAX_PRINTED    = 40;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_item;
    logic      o_busy;
    logic      o_done;
    t_out_item o_result;

    // predicted conversions waiting for their o_done strobe, oldest first
    t_out_item expected_results[$];

    int err_count       = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int stall_cycles    = 0;
    int burst_left      = 0;
    int func_count[8];

    mbf_ieee_format_converter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bit-exact conversion of one item, written from the format rules
    function automatic t_out_item predict_conversion(t_in_item it);
        t_out_item   r;
        logic [10:0] dexp;
        logic [52:0] dman;
        logic [7:0]  sexp;
        logic [8:0]  nexp;
        logic [23:0] nman;
        logic        round_up;
        r = '0;
        case (it.func)
            FUNC_MBF32_TO_IEEE32: begin
                // mbf bias 128 on 0.1m vs ieee bias 127 on 1.m: exponent drops by 2
                if (it.in_exponent == 8'd0) begin
                    r.out_ieee_word = '0;
                end else if (it.in_exponent <= 8'd2) begin
                    // too small for a normal single, keep only the sign
                    r.out_ieee_word = {32'd0, it.in_sign, 31'd0};
                end else begin
                    r.out_ieee_word = {32'd0, it.in_sign, it.in_exponent - 8'd2,
                                       it.in_mantissa[22:0]};
                end
            end
            FUNC_MBF64_TO_IEEE64: begin
                if (it.in_exponent != 8'd0) begin
                    dexp = {3'd0, it.in_exponent} + DBL_EXP_OFFSET;
                    // drop three mantissa bits, round to nearest even
                    round_up = it.in_mantissa[2] &&
                               (it.in_mantissa[1:0] != 2'd0 || it.in_mantissa[3]);
                    dman = {1'b0, it.in_mantissa[54:3]} + 53'(round_up);
                    if (dman[52]) begin
                        dexp = dexp + 11'd1;
                    end
                    r.out_ieee_word = {it.in_sign, dexp, dman[51:0]};
                end
            end
            FUNC_IEEE32_TO_MBF32: begin
                sexp = it.in_ieee_word[30:23];
                if (sexp == SGL_EXP_SPECIAL || sexp >= SGL_EXP_SAT) begin
                    // inf, nan and exponent overflow saturate
                    r.out_sign     = it.in_ieee_word[31];
                    r.out_exponent = MBF_EXP_MAX;
                    r.out_mantissa = MAN_ALL_ONES23;
                end else if (sexp != 8'd0) begin
                    r.out_sign     = it.in_ieee_word[31];
                    r.out_exponent = sexp + 8'd2;
                    r.out_mantissa = {32'd0, it.in_ieee_word[22:0]};
                end
            end
            FUNC_IEEE64_TO_MBF64: begin
                dexp = it.in_ieee_word[62:52];
                if (dexp == DBL_EXP_SPECIAL || dexp >= DBL_EXP_SAT) begin
                    r.out_sign     = it.in_ieee_word[63];
                    r.out_exponent = MBF_EXP_MAX;
                    r.out_mantissa = MAN_ALL_ONES55;
                end else if (dexp > DBL_EXP_OFFSET) begin
                    // zero, subnormal and underflow all fall through as mbf zero
                    dexp           = dexp - DBL_EXP_OFFSET;
                    r.out_sign     = it.in_ieee_word[63];
                    r.out_exponent = dexp[7:0];
                    r.out_mantissa = {it.in_ieee_word[51:0], 3'b000};
                end
            end
            FUNC_MBF64_TO_MBF32: begin
                if (it.in_exponent != 8'd0) begin
                    // 32 discarded bits, ties go to the even 23-bit mantissa
                    round_up = (it.in_mantissa[31:0] > HALF_LSB32) ||
                               (it.in_mantissa[31:0] == HALF_LSB32 && it.in_mantissa[32]);
                    nman = {1'b0, it.in_mantissa[54:32]} + 24'(round_up);
                    nexp = {1'b0, it.in_exponent} + 9'(nman[23]);
                    r.out_sign = it.in_sign;
                    if (nexp[8]) begin
                        r.out_exponent = MBF_EXP_MAX;
                        r.out_mantissa = MAN_ALL_ONES23;
                    end else begin
                        r.out_exponent = nexp[7:0];
                        r.out_mantissa = {32'd0, nman[22:0]};
                    end
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        end
    endtask

    // result checking, item prediction and the watchdog, all on the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    o_result.out_ieee_word, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.out_ieee_word !== want.out_ieee_word) begin
                        report_mismatch("out_ieee_word", o_result.out_ieee_word,
                                        want.out_ieee_word);
                    end
                    if (o_result.out_sign !== want.out_sign) begin
                        report_mismatch("out_sign", 64'(o_result.out_sign),
                                        64'(want.out_sign));
                    end
                    if (o_result.out_exponent !== want.out_exponent) begin
                        report_mismatch("out_exponent", 64'(o_result.out_exponent),
                                        64'(want.out_exponent));
                    end
                    if (o_result.out_mantissa !== want.out_mantissa) begin
                        report_mismatch("out_mantissa", 64'(o_result.out_mantissa),
                                        64'(want.out_mantissa));
                    end
                    results_checked++;
                end
            end
            // an item is taken when start meets a low busy
            if (i_start && !o_busy) begin
                expected_results.push_back(predict_conversion(i_item));
                func_count[i_item.func]++;
                items_sent++;
            end
            if (o_done || (i_start && !o_busy)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no item or result for %0d cycles",
                         $realtime, WATCHDOG_LIMIT);
                $display("mbf_ieee_format_converter_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic t_in_item mk_item(logic [2:0] func, logic sign, logic [7:0] exp_in,
                                         logic [54:0] man, logic [63:0] word);
        t_in_item it;
        it.func         = func;
        it.in_sign      = sign;
        it.in_exponent  = exp_in;
        it.in_mantissa  = man;
        it.in_ieee_word = word;
        return it;
    endfunction

    // present one item and hold it until taken; start stays high within a burst
    task automatic send_item(t_in_item it);
        int gap;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 4) == 0) ? 0 :
                  ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            if (gap > 0) begin
                // junk on the payload while start is low must be ignored
                @(negedge i_clk);
                i_start <= 1'b0;
                i_item  <= random_item();
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // hold off until every predicted result has been checked
    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic test_mbf_to_ieee();
        // mbf zero ignores sign and mantissa
        send_item(mk_item(FUNC_MBF32_TO_IEEE32, 1'b1, 8'd0, '1, '0));
        // exponents one and two underflow the single to a signed zero
        send_item(mk_item(FUNC_MBF32_TO_IEEE32, 1'b1, 8'd1, 55'h7F_FFFF, '0));
        send_item(mk_item(FUNC_MBF32_TO_IEEE32, 1'b0, 8'd2, 55'h1234, '0));
        // mantissa bits above 22 are dropped
        send_item(mk_item(FUNC_MBF32_TO_IEEE32, 1'b1, 8'd255, '1, '0));
        send_item(mk_item(FUNC_MBF64_TO_IEEE64, 1'b1, 8'd0, '1, '1));
        // all-ones mantissa rounds up and carries into the exponent
        send_item(mk_item(FUNC_MBF64_TO_IEEE64, 1'b0, 8'd255, '1, '0));
        // exact ties: even keep stays, odd keep rounds up
        send_item(mk_item(FUNC_MBF64_TO_IEEE64, 1'b0, 8'd128, 55'h14, '0));
        send_item(mk_item(FUNC_MBF64_TO_IEEE64, 1'b1, 8'd128, 55'h0C, '0));
    endtask

    task automatic test_ieee_to_mbf();
        send_item(mk_item(FUNC_IEEE32_TO_MBF32, 1'b0, 8'd0, '0, 64'h0000_0000_8000_0000));
        // subnormal single, upper half of the word is junk
        send_item(mk_item(FUNC_IEEE32_TO_MBF32, 1'b0, 8'd0, '0, 64'hFFFF_FFFF_0000_0001));
        send_item(mk_item(FUNC_IEEE32_TO_MBF32, 1'b0, 8'd0, '0, 64'h0000_0000_FF80_0000));
        // largest exponent that still fits, then the first that saturates
        send_item(mk_item(FUNC_IEEE32_TO_MBF32, 1'b0, 8'd0, '0, 64'h0000_0000_7E81_2345));
        send_item(mk_item(FUNC_IEEE32_TO_MBF32, 1'b0, 8'd0, '0, 64'h0000_0000_7F00_0000));
        send_item(mk_item(FUNC_IEEE32_TO_MBF32, 1'b0, 8'd0, '0, 64'hDEAD_BEEF_0080_0001));
        send_item(mk_item(FUNC_IEEE64_TO_MBF64, 1'b0, 8'd0, '0, 64'h7FF8_0000_0000_0001));
        // underflow edge, first exponent that lands, last that fits, first that saturates
        send_item(mk_item(FUNC_IEEE64_TO_MBF64, 1'b0, 8'd0, '0, 64'h37E0_0000_0000_0001));
        send_item(mk_item(FUNC_IEEE64_TO_MBF64, 1'b0, 8'd0, '0, 64'hB7F0_0000_0000_0003));
        send_item(mk_item(FUNC_IEEE64_TO_MBF64, 1'b0, 8'd0, '0, 64'h47DF_FFFF_FFFF_FFFF));
        send_item(mk_item(FUNC_IEEE64_TO_MBF64, 1'b0, 8'd0, '0, 64'hC7E0_0000_0000_0000));
    endtask

    task automatic test_mbf64_to_mbf32();
        send_item(mk_item(FUNC_MBF64_TO_MBF32, 1'b1, 8'd0, '1, '0));
        // ties to even on the 32 dropped bits
        send_item(mk_item(FUNC_MBF64_TO_MBF32, 1'b0, 8'd40, {23'h2, 32'h8000_0000}, '0));
        send_item(mk_item(FUNC_MBF64_TO_MBF32, 1'b1, 8'd40, {23'h3, 32'h8000_0000}, '0));
        // above half with a full mantissa: carry into the exponent
        send_item(mk_item(FUNC_MBF64_TO_MBF32, 1'b0, 8'd100, {23'h7F_FFFF, 32'h8000_0001}, '0));
        // same carry at the top exponent saturates
        send_item(mk_item(FUNC_MBF64_TO_MBF32, 1'b1, 8'd255, '1, '0));
    endtask

    task automatic test_unused_codes();
        send_item(mk_item(FUNC_UNUSED_LAST, 1'b1, 8'd255, '1, '1));
    endtask

    function automatic t_in_item random_item();
        t_in_item    it;
        logic [63:0] w;
        logic [54:0] m;
        it.func    = ($urandom_range(0, 19) == 0) ?
                     3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)) :
                     3'($urandom_range(FUNC_MBF32_TO_IEEE32, FUNC_MBF64_TO_MBF32));
        it.in_sign = 1'($urandom_range(0, 1));
        // exponents near the underflow and overflow edges get extra weight
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 6))
                    0: it.in_exponent = 8'd0;
                    1: it.in_exponent = 8'd1;
                    2: it.in_exponent = 8'd2;
                    3: it.in_exponent = 8'd3;
                    4: it.in_exponent = 8'd253;
                    5: it.in_exponent = 8'd254;
                    default: it.in_exponent = 8'd255;
                endcase
            end
            default: it.in_exponent = 8'($urandom);
        endcase
        m = 55'({$urandom, $urandom});
        case ($urandom_range(0, 7))
            0: m[31:0] = HALF_LSB32;
            1: m[2:0]  = 3'b100;
            2: m       = '1;
            default: ;
        endcase
        it.in_mantissa = m;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: w[30:23] = 8'd0;
                    1: w[30:23] = 8'd1;
                    2: w[30:23] = 8'd253;
                    3: w[30:23] = SGL_EXP_SAT;
                    default: w[30:23] = SGL_EXP_SPECIAL;
                endcase
            end
            1: begin
                case ($urandom_range(0, 6))
                    0: w[62:52] = 11'd0;
                    1: w[62:52] = DBL_EXP_OFFSET;
                    2: w[62:52] = DBL_EXP_OFFSET + 11'd1;
                    3: w[62:52] = DBL_EXP_SAT - 11'd1;
                    4: w[62:52] = DBL_EXP_SAT;
                    5: w[62:52] = DBL_EXP_SPECIAL - 11'd1;
                    default: w[62:52] = DBL_EXP_SPECIAL;
                endcase
            end
            // double exponents mostly random land outside the band that fits, so aim inside
            2: w[62:52] = DBL_EXP_OFFSET + 11'($urandom_range(1, 255));
            default: ;
        endcase
        it.in_ieee_word = w;
        return it;
    endfunction

    task automatic test_random_conversions();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // pause for a full drain now and then
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
            end
            send_item(random_item());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_mbf_to_ieee();
        test_ieee_to_mbf();
        test_mbf64_to_mbf32();
        test_unused_codes();
        test_random_conversions();

        // last items out, then keep the clock running to catch stray strobes
        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("results never delivered", 64'(expected_results.size()), '0);
        end

        $display("mbf_ieee_format_converter_tb: %0d items, %0d results checked, %0d mismatches",
                 items_sent, results_checked, err_count);
        $display("  per func 0..7: %0d %0d %0d %0d %0d / unused %0d %0d %0d",
                 func_count[0], func_count[1], func_count[2], func_count[3],
                 func_count[4], func_count[5], func_count[6], func_count[7]);
        if (err_count == 0) begin
            $display("mbf_ieee_format_converter_tb: done, clean");
        end else begin
            $display("mbf_ieee_format_converter_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
